>>> rtl/ssd_pkg.sv
// Shared constants, action codes and glyph lookup for the seven-segment driver.
package ssd_pkg;

   localparam int DIGIT_COUNT_DEF = 4;
   localparam int FRAME_DIGITS = 4;

   localparam logic [1:0] ACT_VALUE = 2'd0;
   localparam logic [1:0] ACT_ERROR = 2'd1;
   localparam logic [1:0] ACT_TICK  = 2'd2;

   localparam logic [7:0] PAT_MINUS = 8'h40;
   localparam logic [7:0] PAT_ERROR = 8'hF9;
   localparam logic [7:0] PAT_BLANK = 8'h00;

   // reciprocal multipliers for dividing 16-bit unsigned values
   localparam logic [16:0] RECIP_10    = 17'd52429;
   localparam logic [16:0] RECIP_100   = 17'd83887;
   localparam logic [16:0] RECIP_1000  = 17'd67109;
   localparam logic [16:0] RECIP_10000 = 17'd107375;

   function automatic logic [7:0] glyph_of(input logic [7:0] d);
      logic [7:0] pat;
      case (d)
         8'd0: pat = 8'h3F;
         8'd1: pat = 8'h06;
         8'd2: pat = 8'h5B;
         8'd3: pat = 8'h4F;
         8'd4: pat = 8'h66;
         8'd5: pat = 8'h6D;
         8'd6: pat = 8'h7D;
         8'd7: pat = 8'h27;
         8'd8: pat = 8'h7F;
         8'd9: pat = 8'h6F;
         default: pat = PAT_MINUS;
      endcase
      return pat;
   endfunction

endpackage

>>> rtl/ssd_frame_gen.sv
// Decimal split and segment frame builder: quotient stage, then digit glyphs.
module ssd_frame_gen #(
   parameter int DIGIT_COUNT = ssd_pkg::DIGIT_COUNT_DEF
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     is_error,
   input  logic [15:0]              shown_value,
   input  logic [7:0]               fault_code,
   output logic [DIGIT_COUNT*8-1:0] frame_row
);

   logic [32:0] p1, p2, p3, p4;
   logic [15:0] v_ff;
   logic [12:0] q1_ff;
   logic [9:0]  q2_ff;
   logic [6:0]  q3_ff;
   logic [2:0]  q4_ff;
   logic [7:0]  code_ff;
   logic        err_ff;

   always_comb begin
      p1 = 33'(shown_value) * 33'(ssd_pkg::RECIP_10);
      p2 = 33'(shown_value) * 33'(ssd_pkg::RECIP_100);
      p3 = 33'(shown_value) * 33'(ssd_pkg::RECIP_1000);
      p4 = 33'(shown_value) * 33'(ssd_pkg::RECIP_10000);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff    <= shown_value;
         q1_ff   <= p1[31:19];
         q2_ff   <= p2[32:23];
         q3_ff   <= p3[32:26];
         q4_ff   <= p4[32:30];
         code_ff <= fault_code;
         err_ff  <= is_error;
      end
   end

   logic [15:0] m0;
   logic [12:0] m1;
   logic [9:0]  m2;
   logic [6:0]  m3;
   logic [3:0]  d0, d1, d2, d3;
   logic [7:0]  pats [ssd_pkg::FRAME_DIGITS];

   always_comb begin
      m0 = ({3'b000, q1_ff} << 3) + ({3'b000, q1_ff} << 1);
      m1 = ({3'b000, q2_ff} << 3) + ({3'b000, q2_ff} << 1);
      m2 = ({3'b000, q3_ff} << 3) + ({3'b000, q3_ff} << 1);
      m3 = ({4'b0000, q4_ff} << 3) + ({4'b0000, q4_ff} << 1);
      d0 = 4'(v_ff - m0);
      d1 = 4'(q1_ff - m1);
      d2 = 4'(q2_ff - m2);
      d3 = 4'(q3_ff - m3);
      if (err_ff) begin
         pats[0] = ssd_pkg::glyph_of(code_ff);
         pats[1] = ssd_pkg::PAT_ERROR;
         pats[2] = ssd_pkg::PAT_BLANK;
         pats[3] = ssd_pkg::PAT_BLANK;
      end else begin
         pats[0] = ssd_pkg::glyph_of({4'b0000, d0});
         pats[1] = ssd_pkg::glyph_of({4'b0000, d1});
         pats[2] = ssd_pkg::glyph_of({4'b0000, d2});
         pats[3] = (d3 == 4'd0) ? ssd_pkg::PAT_MINUS : ssd_pkg::glyph_of({4'b0000, d3});
      end
   end

   // positions past the four shown digits keep the minus glyph
   always_comb begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         if (i < ssd_pkg::FRAME_DIGITS) begin
            frame_row[i*8 +: 8] = pats[i];
         end else begin
            frame_row[i*8 +: 8] = ssd_pkg::PAT_MINUS;
         end
      end
   end

endmodule

>>> rtl/seven_segment_mux_display_driver.sv
// Top level of the multiplexed seven-segment display driver.
//
// Request channel (req_): one transaction per action. Show value and show
// error rewrite the stored frame and produce no response. A scan tick reads
// the frame and produces one response (rsp_) carrying the active-low segment
// byte of the digit under the scan pointer and that digit's index; the
// pointer then steps to the next digit, wrapping after DIGIT_COUNT.
// The frame lives in a single-row memory with a registered read; a frame
// write is visible to any tick accepted on a later cycle.
// Throughput: one transaction per cycle, any mix of actions, while not stalled.
// Pipeline: a tick passes the split/frame stage, the memory read stage and
// the output register in turn before rsp_valid rises.
// Reset: pointer cleared, frame row marked unwritten so every digit reads as
// the minus glyph; no transaction in flight.
// Stall: while the output register holds a response that is not taken, the
// whole pipeline holds and req_ready is low; it frees in the cycle the
// response is taken.
module seven_segment_mux_display_driver #(
   parameter int DIGIT_COUNT = ssd_pkg::DIGIT_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [15:0] req_shown_value,
   input  logic [7:0]  req_fault_code,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_segment_byte,
   output logic [1:0]  rsp_digit_index
);

   localparam int RowW = DIGIT_COUNT * 8;
   localparam int PtrW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

   logic            advance;
   logic            accept;
   logic            a_vld_ff;
   logic [1:0]      a_act_ff;
   logic [RowW-1:0] frame_row;
   logic            a_write, a_tick;

   logic [RowW-1:0] frame_mem [1];
   logic            frame_valid_ff;
   logic [RowW-1:0] rd_data_ff;
   logic            rd_hit_ff;

   logic [PtrW-1:0] ptr_ff, ptr_in;
   logic            c_vld_ff;
   logic [PtrW-1:0] c_ptr_ff;
   logic [7:0]      c_byte;

   logic            rsp_valid_ff;
   logic [7:0]      seg_ff;
   logic [1:0]      idx_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && req_ready;

   ssd_frame_gen #(.DIGIT_COUNT(DIGIT_COUNT)) u_frame_gen (
      .clock      (clock),
      .en         (advance),
      .is_error   (req_action == ssd_pkg::ACT_ERROR),
      .shown_value(req_shown_value),
      .fault_code (req_fault_code),
      .frame_row  (frame_row)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (advance) begin
         a_vld_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_act_ff <= req_action;
      end
   end

   assign a_write = a_vld_ff && (a_act_ff == ssd_pkg::ACT_VALUE ||
                                 a_act_ff == ssd_pkg::ACT_ERROR);
   assign a_tick  = a_vld_ff && (a_act_ff == ssd_pkg::ACT_TICK);

   // frame memory: one row, written whole, registered read
   always_ff @(posedge clock) begin
      if (advance && a_write) begin
         frame_mem[0] <= frame_row;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && a_tick) begin
         rd_data_ff <= frame_mem[0];
         rd_hit_ff  <= frame_valid_ff;
         c_ptr_ff   <= ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_valid_ff <= 1'b0;
      end else if (advance && a_write) begin
         frame_valid_ff <= 1'b1;
      end
   end

   always_comb begin
      if (ptr_ff == PtrW'(DIGIT_COUNT - 1)) begin
         ptr_in = '0;
      end else begin
         ptr_in = ptr_ff + PtrW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff   <= '0;
         c_vld_ff <= 1'b0;
      end else if (advance) begin
         c_vld_ff <= a_tick;
         if (a_tick) begin
            ptr_ff <= ptr_in;
         end
      end
   end

   assign c_byte = rd_hit_ff ? rd_data_ff[c_ptr_ff*8 +: 8] : ssd_pkg::PAT_MINUS;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && c_vld_ff) begin
         seg_ff <= ~c_byte;
         idx_ff <= 2'(c_ptr_ff);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_segment_byte = seg_ff;
   assign rsp_digit_index  = idx_ff;

`ifndef SYNTH
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      32'(ptr_ff) < DIGIT_COUNT)
      else $error("scan pointer out of range");

   a_tick_reaches_out: assert property (@(posedge clock) disable iff (reset)
      (c_vld_ff && advance) |=> rsp_valid_ff)
      else $error("read tick lost before output register");

   a_ptr_step: assert property (@(posedge clock) disable iff (reset)
      (a_tick && advance && ptr_ff != PtrW'(DIGIT_COUNT - 1))
      |=> ptr_ff == $past(ptr_ff) + PtrW'(1))
      else $error("scan pointer did not step on tick");

   a_ptr_hold: assert property (@(posedge clock) disable iff (reset)
      !(a_tick && advance) |=> $stable(ptr_ff))
      else $error("scan pointer moved without a tick");
`endif

endmodule
